[rtl/otsc_pkg.sv]
// shared types, constants and crc function for the scratchpad checker
package otsc_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    localparam logic [7:0] CRC_POLY = 8'h8C;
    localparam logic [3:0] OFFSET_RESET = 4'hF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic              last;
        logic signed [7:0] temperature;
        logic              crc_ok;
    } t_core_res;

    // reflected crc-8, lsb first, one byte
    function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                               input logic [7:0] data_in);
        logic [7:0] crc;
        logic [7:0] d;
        logic       fb;
        crc = crc_in;
        d   = data_in;
        for (int k = 0; k < 8; k++) begin
            fb  = crc[0] ^ d[0];
            crc = {1'b0, crc[7:1]};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return crc;
    endfunction

endpackage

[rtl/otsc_ifs.sv]
// channel interfaces: byte input, result output, offset write
interface otsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface otsc_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] temperature;
    logic              crc_ok;

    modport source (output valid, output temperature, output crc_ok, input ready);
    modport sink   (input valid, input temperature, input crc_ok, output ready);
endinterface

interface otsc_cfg_if;
    logic              valid;
    logic              ready;
    logic signed [3:0] temp_offset;

    modport source (output valid, output temp_offset, input ready);
    modport sink   (input valid, input temp_offset, output ready);
endinterface

[rtl/otsc_in_stage.sv]
// input register stage for scratchpad bytes
module otsc_in_stage import otsc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    otsc_in_if.sink        i_in,
    input  logic           i_adv,
    output logic           o_valid,
    output t_in_item       o_item
);

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign i_in.ready = !r_valid || i_adv;

    always_comb begin
        n_valid = r_valid;
        if (i_in.ready) begin
            n_valid = i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.data_byte   <= i_in.data_byte;
            r_item.frame_start <= i_in.frame_start;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/otsc_frame_core.sv]
// frame state: crc accumulator, byte index, raw reading and decode
module otsc_frame_core import otsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_in_item          i_item,
    input  logic signed [3:0] i_offset,
    output t_core_res         o_res
);

    logic [7:0]       r_crc;
    logic [7:0]       n_crc;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [7:0]       r_raw_low;
    logic [7:0]       r_raw_high;

    logic [IDX_W-1:0] eff_idx;
    logic [7:0]       crc_base;
    logic [7:0]       crc_new;
    logic             is_last;
    logic [7:0]       t_base;
    logic             neg_adj;
    logic [7:0]       t_sum;

    // start mark restarts the frame on this byte
    assign eff_idx  = i_item.frame_start ? '0 : r_idx;
    assign crc_base = i_item.frame_start ? 8'h00 : r_crc;
    assign crc_new  = crc8_update(crc_base, i_item.data_byte);
    assign is_last  = (eff_idx == LAST_IDX);

    // floor(raw/16); negative readings round one lower when bit 3 is set
    assign t_base  = {r_raw_high[3:0], r_raw_low[7:4]};
    assign neg_adj = (r_raw_high[7:4] != 4'h0) && r_raw_low[3];
    assign t_sum   = t_base - {7'd0, neg_adj} + {{4{i_offset[3]}}, i_offset};

    assign o_res.last        = is_last;
    assign o_res.temperature = t_sum;
    assign o_res.crc_ok      = (crc_new == 8'h00);

    always_comb begin
        n_idx = r_idx;
        n_crc = r_crc;
        if (i_adv) begin
            if (is_last) begin
                n_idx = '0;
                n_crc = 8'h00;
            end else begin
                n_idx = eff_idx + IDX_W'(1);
                n_crc = crc_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_crc <= 8'h00;
        end else begin
            r_idx <= n_idx;
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && (eff_idx == IDX_W'(0))) begin
            r_raw_low <= i_item.data_byte;
        end
        if (i_adv && (eff_idx == IDX_W'(1))) begin
            r_raw_high <= i_item.data_byte;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("byte index beyond frame");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && is_last) |=> (r_idx == '0) && (r_crc == 8'h00))
        else $error("frame state not cleared after last byte");

    a_start_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_item.frame_start) |=> (r_idx == IDX_W'(1)))
        else $error("start mark did not restart frame");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_idx) && $stable(r_crc))
        else $error("frame state moved without a request");

endmodule

[rtl/otsc_out_stage.sv]
// result register for decoded temperature and crc flag
module otsc_out_stage import otsc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_core_res    i_res,
    output logic         o_room,
    otsc_out_if.source   o_out
);

    logic              r_valid;
    logic              n_valid;
    logic signed [7:0] r_temperature;
    logic              r_crc_ok;

    assign o_room = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid && !o_out.ready;
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_temperature <= i_res.temperature;
            r_crc_ok      <= i_res.crc_ok;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.temperature = r_temperature;
    assign o_out.crc_ok      = r_crc_ok;

endmodule

[rtl/onewire_temp_scratchpad_check_top.sv]
// top level of the one-wire temperature scratchpad checker
//
// usage:
//   i_in carries one scratchpad byte per request (data_byte) and a frame_start
//   mark for byte 0 of a frame; unmarked bytes continue the current frame, so
//   back-to-back frames need no marks. a mark in mid-frame drops the partial
//   frame and restarts on that byte.
//   o_out gives one request per frame, on its last byte: the whole-degree
//   temperature (8-bit two's complement, wraps) and crc_ok for the crc-8
//   over all bytes of the frame, stored crc byte included.
//   i_cfg writes the signed 4-bit temp_offset; it is always ready. write it
//   only while no frame is in flight.
// timing:
//   one byte per cycle sustained while o_out does not stall; a byte is held in the
//   input register, then the crc update and decode load the result register
//   from it, and o_out is driven from that register.
//   when o_out stalls, bytes that make no result keep flowing; the last byte
//   of the next frame waits in the input register until the result is taken.
// reset:
//   synchronous, active low; clears frame position, crc, both valids and
//   sets temp_offset to -1.
module onewire_temp_scratchpad_check_top import otsc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    otsc_in_if.sink      i_in,
    otsc_cfg_if.sink     i_cfg,
    otsc_out_if.source   o_out
);

    logic              in_valid;
    t_in_item          in_item;
    t_core_res         core_res;
    logic              out_room;
    logic              adv;
    logic signed [3:0] r_offset;

    // offset register, writes taken every cycle
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
        end else if (i_cfg.valid) begin
            r_offset <= i_cfg.temp_offset;
        end
    end

    // a byte moves on unless it makes a result and the result slot is full
    assign adv = in_valid && (!core_res.last || out_room);

    otsc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    otsc_frame_core u_frame_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (in_item),
        .i_offset (r_offset),
        .o_res    (core_res)
    );

    otsc_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && core_res.last),
        .i_res   (core_res),
        .o_room  (out_room),
        .o_out   (o_out)
    );

endmodule
